FILE: design/ecdm_pkg.sv
// Shared types and constants for the eye closure drowsiness monitor.
// No dependencies; imported by eye_closure_drowsiness_monitor.
package ecdm_pkg;

    // Width of the internal time base; timestamps wrap modulo 2^TIME_WIDTH
    localparam int TIME_WIDTH = 32;
    // Width used for duration compares: the time base or the 32-bit outputs
    localparam int DUR_WIDTH  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_WIDTH     = 16;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [DUR_WIDTH-1:0]  t_dur;
    typedef logic [CFG_WIDTH-1:0]  t_cfg;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_BLINK_MIN  = 3'd0,
        REG_BLINK_MAX  = 3'd1,
        REG_DROWSY_LIM = 3'd2,
        REG_ALERT_LIM  = 3'd3
    } t_reg_idx;

    localparam t_cfg BLINK_MIN_RST  = 16'd50;
    localparam t_cfg BLINK_MAX_RST  = 16'd500;
    localparam t_cfg DROWSY_LIM_RST = 16'd1000;
    localparam t_cfg ALERT_LIM_RST  = 16'd2000;

    typedef enum logic [1:0] {
        LEVEL_UNKNOWN = 2'd0,
        LEVEL_OK      = 2'd1,
        LEVEL_DROWSY  = 2'd2,
        LEVEL_ALERT   = 2'd3
    } t_level;

    // One result beat
    typedef struct packed {
        logic        seen_open;
        logic        closed_now;
        logic [31:0] closed_ms;
        logic [31:0] blink_total;
        t_level      level;
        logic        error;
    } t_result;

endpackage

FILE: design/eye_closure_drowsiness_monitor.sv
// Eye closure drowsiness monitor: tracks closure time, counts blinks, grades level.
// Depends on ecdm_pkg for types, register indexes and reset values.
//
// Each accepted beat is one eye observation (visible flag, ms timestamp) and yields
// exactly one result beat. An observation is not pipelined: the tracking state
// updates at the accepting edge and the result lands in an output register, backed by
// a one-entry skid register, so a new observation can be accepted every cycle, also
// while a result still waits downstream. o_in_ready drops only when both the output
// and the skid register are full. A zero timestamp, or one earlier than the start of
// the current closure, returns the previous result with o_error set and leaves all
// state alone. Configuration writes are always ready and take effect at once; indexes
// beyond the four registers are ignored.
module eye_closure_drowsiness_monitor
    import ecdm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    // observation channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_eyes_visible,
    input  logic [31:0]              i_time_ms,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_seen_open,
    output logic                     o_closed_now,
    output logic [31:0]              o_closed_ms,
    output logic [31:0]              o_blink_total,
    output logic [1:0]               o_level,
    output logic                     o_error
);

    // Configuration registers
    t_cfg r_blink_min, r_blink_max, r_drowsy_lim, r_alert_lim;

    // Tracking state
    logic        r_eyes_shut, n_eyes_shut;
    t_time       r_shut_start, n_shut_start;
    logic [31:0] r_blinks, n_blinks;
    logic        r_last_open, n_last_open;
    logic        r_last_closed, n_last_closed;
    logic [31:0] r_last_closed_ms, n_last_closed_ms;
    t_level      r_last_level, n_last_level;

    // Output register and skid register
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic    in_acc, out_take, time_err;
    t_time   t_now, dur;
    t_dur    dur_ext;
    logic    in_window;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~r_skid_valid;
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_take    = r_out_valid & i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_min  <= BLINK_MIN_RST;
            r_blink_max  <= BLINK_MAX_RST;
            r_drowsy_lim <= DROWSY_LIM_RST;
            r_alert_lim  <= ALERT_LIM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BLINK_MIN:  r_blink_min  <= i_cfg_data;
                REG_BLINK_MAX:  r_blink_max  <= i_cfg_data;
                REG_DROWSY_LIM: r_drowsy_lim <= i_cfg_data;
                REG_ALERT_LIM:  r_alert_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Timing check and closure length (one subtractor serves both paths)
    always_comb begin
        t_now     = TIME_WIDTH'(i_time_ms);
        time_err  = (t_now == '0) || (r_eyes_shut && (t_now < r_shut_start));
        dur       = r_eyes_shut ? (t_now - r_shut_start) : '0;
        dur_ext   = DUR_WIDTH'(dur);
        in_window = (dur_ext >= DUR_WIDTH'(r_blink_min)) &&
                    (dur_ext <= DUR_WIDTH'(r_blink_max));
    end

    // Next tracking state for an accepted observation
    always_comb begin
        n_eyes_shut      = r_eyes_shut;
        n_shut_start     = r_shut_start;
        n_blinks         = r_blinks;
        n_last_open      = r_last_open;
        n_last_closed    = r_last_closed;
        n_last_closed_ms = r_last_closed_ms;
        n_last_level     = r_last_level;
        if (!time_err) begin
            n_last_open = i_eyes_visible;
            if (i_eyes_visible) begin
                // reopen: count a blink if the closure fit the window and the counter is not saturated
                if (r_eyes_shut && in_window && (r_blinks != '1)) begin
                    n_blinks = r_blinks + 32'd1;
                end
                n_eyes_shut      = 1'b0;
                n_last_closed    = 1'b0;
                n_last_closed_ms = '0;
                n_last_level     = LEVEL_OK;
            end else begin
                if (!r_eyes_shut) begin
                    n_eyes_shut  = 1'b1;
                    n_shut_start = t_now;
                end
                n_last_closed    = 1'b1;
                n_last_closed_ms = (dur_ext > DUR_WIDTH'(32'hFFFF_FFFF)) ?
                                   32'hFFFF_FFFF : 32'(dur_ext);
                // alert is tested first so it wins if limits cross
                if (dur_ext >= DUR_WIDTH'(r_alert_lim)) begin
                    n_last_level = LEVEL_ALERT;
                end else if (dur_ext >= DUR_WIDTH'(r_drowsy_lim)) begin
                    n_last_level = LEVEL_DROWSY;
                end else begin
                    n_last_level = LEVEL_OK;
                end
            end
        end
    end

    // Result beat mirrors the updated state
    always_comb begin
        res.seen_open   = n_last_open;
        res.closed_now  = n_last_closed;
        res.closed_ms   = n_last_closed_ms;
        res.blink_total = n_blinks;
        res.level       = n_last_level;
        res.error       = time_err;
    end

    // Output and skid register control
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_take) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (in_acc) begin
            if (!r_out_valid || out_take) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eyes_shut      <= 1'b0;
            r_shut_start     <= '0;
            r_blinks         <= '0;
            r_last_open      <= 1'b0;
            r_last_closed    <= 1'b0;
            r_last_closed_ms <= '0;
            r_last_level     <= LEVEL_UNKNOWN;
            r_out_valid      <= 1'b0;
            r_skid_valid     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_eyes_shut      <= n_eyes_shut;
                r_shut_start     <= n_shut_start;
                r_blinks         <= n_blinks;
                r_last_open      <= n_last_open;
                r_last_closed    <= n_last_closed;
                r_last_closed_ms <= n_last_closed_ms;
                r_last_level     <= n_last_level;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_seen_open   = r_out.seen_open;
    assign o_closed_now  = r_out.closed_now;
    assign o_closed_ms   = r_out.closed_ms;
    assign o_blink_total = r_out.blink_total;
    assign o_level       = r_out.level;
    assign o_error       = r_out.error;

    // Skid register is only filled behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while output register is empty");

    // A rejected observation leaves the tracking state alone
    a_err_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && time_err) |=> ($stable(r_blinks) && $stable(r_shut_start) &&
                                  $stable(r_eyes_shut) && $stable(r_last_level)))
        else $error("timing error changed tracking state");

    // Blink counter never goes down outside reset
    a_blinks_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_blinks >= $past(r_blinks)))
        else $error("blink counter decreased");

    // Reported closure flag follows the tracker and excludes an open report
    a_closed_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_closed == r_eyes_shut) && !(r_last_closed && r_last_open))
        else $error("closure flags inconsistent");

endmodule
